>>> design/sirtd_pkg.sv
// ----------------------------------------------------------------------------
// sirtd_pkg: shared types and constants for the radix digit unit
// Request and result structs, opcodes, special symbols and sequencer states.
// ----------------------------------------------------------------------------
package sirtd_pkg;

  localparam int MAX_SYMBOLS = 256;
  localparam int MAX_DIGITS  = 32;
  localparam int VALUE_W     = 32;
  localparam int SYM_W       = 8;
  localparam int SYM_COUNT   = 2 ** SYM_W;
  localparam int LEN_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int ADDR_W      = $clog2(MAX_SYMBOLS);
  localparam int DCNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int DIDX_W      = $clog2(MAX_DIGITS);
  localparam int BIT_W       = $clog2(VALUE_W);

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [SYM_W-1:0]         symbol;
    logic signed [VALUE_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_char;
    logic             last;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIV,
    ST_RD,
    ST_LOAD,
    ST_OUT
  } state_t;

endpackage

>>> design/sirtd_ram.sv
// ----------------------------------------------------------------------------
// sirtd_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sirtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/signed_integer_to_radix_digits_unit.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_unit: signed value to alphabet digit string
// Holds a digit alphabet loaded by clear and append requests and converts a
// signed 32-bit value into a sign and digit symbols, most significant first.
// ----------------------------------------------------------------------------
// sequence: clear and append are done in the idle state; a convert passes a minus sign
//   through ST_SIGN, runs one full division per digit (none for zero) and steps each digit
//   character through ST_RD, ST_LOAD and ST_OUT; requests are taken one at a time and the
//   unit stays busy until the conversion is done; the divider yields one bit a cycle
// reset: sequencer idle, no output pending, alphabet empty and good, seen map
//   cleared; alphabet memory contents stay undefined until written
module signed_integer_to_radix_digits_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sirtd_pkg::in_req_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sirtd_pkg::out_rsp_t out_data
);
  import sirtd_pkg::*;

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_SYMBOLS);

  // sequencer and alphabet bookkeeping
  state_t               state_r, state_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic                 bad_r, bad_nxt;
  logic [SYM_COUNT-1:0] seen_r, seen_nxt;

  // divider working registers
  logic [LEN_W-1:0]     radix_r, radix_nxt;
  logic [LEN_W-1:0]     rem_r, rem_nxt;
  logic [VALUE_W-1:0]   quo_r, quo_nxt;
  logic [BIT_W-1:0]     cnt_r, cnt_nxt;

  // digit buffer, filled least significant first and drained in reverse
  logic [ADDR_W-1:0]    digs_r [MAX_DIGITS];
  logic [DCNT_W-1:0]    ndig_r, ndig_nxt;
  logic [DIDX_W-1:0]    idx_r, idx_nxt;
  logic                 dig_we;
  logic [DIDX_W-1:0]    dig_waddr;
  logic [ADDR_W-1:0]    dig_wdata;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  out_rsp_t             out_rsp_r, out_rsp_nxt;

  // alphabet memory port
  logic                 ram_we, ram_re;
  logic [SYM_W-1:0]     ram_rdata;

  // divider step: shift in the next dividend bit and try to subtract radix
  logic [LEN_W:0]       trial;
  logic                 trial_ge;
  logic [LEN_W:0]       trial_diff;
  logic [LEN_W-1:0]     rem_step;
  logic [VALUE_W-1:0]   quo_step;

  // magnitude of the incoming value, exact for the most negative value too
  logic                 val_neg;
  logic [VALUE_W-1:0]   val_mag;

  assign val_neg = in_data.value[VALUE_W-1];
  assign val_mag = val_neg ? (VALUE_W'(0) - $unsigned(in_data.value))
                           : $unsigned(in_data.value);

  assign trial      = {rem_r, quo_r[VALUE_W-1]};
  assign trial_ge   = (trial >= {1'b0, radix_r});
  assign trial_diff = trial - {1'b0, radix_r};
  assign rem_step   = trial_ge ? trial_diff[LEN_W-1:0] : trial[LEN_W-1:0];
  assign quo_step   = {quo_r[VALUE_W-2:0], trial_ge};

  sirtd_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_alpha_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (in_data.symbol),
    .re    (ram_re),
    .raddr (digs_r[idx_r]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      bad_r       <= 1'b0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      bad_r       <= bad_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    radix_r   <= radix_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    ndig_r    <= ndig_nxt;
    idx_r     <= idx_nxt;
    out_rsp_r <= out_rsp_nxt;
    if (dig_we) begin
      digs_r[dig_waddr] <= dig_wdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    bad_nxt       = bad_r;
    seen_nxt      = seen_r;
    radix_nxt     = radix_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    ndig_nxt      = ndig_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    dig_we        = 1'b0;
    dig_waddr     = ndig_r[DIDX_W-1:0];
    dig_wdata     = rem_step[ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.opcode)
            OP_CLEAR: begin
              seen_nxt = '0;
              len_nxt  = '0;
              bad_nxt  = 1'b0;
            end
            OP_APPEND: begin
              // a zero symbol is dropped without touching any state
              if (in_data.symbol != '0) begin
                if (len_r == LEN_FULL) begin
                  bad_nxt = 1'b1;
                end else begin
                  if (in_data.symbol == SYM_PLUS || in_data.symbol == SYM_MINUS ||
                      seen_r[in_data.symbol]) begin
                    bad_nxt = 1'b1;
                  end
                  seen_nxt[in_data.symbol] = 1'b1;
                  ram_we  = 1'b1;
                  len_nxt = len_r + 1'b1;
                end
              end
            end
            OP_CONVERT: begin
              // a bad alphabet or one with fewer than two symbols gives nothing
              if (!bad_r && len_r > LEN_W'(1)) begin
                radix_nxt = len_r;
                quo_nxt   = val_mag;
                rem_nxt   = '0;
                cnt_nxt   = '0;
                ndig_nxt  = '0;
                if (val_neg) begin
                  out_rsp_nxt.out_char = SYM_MINUS;
                  out_rsp_nxt.last     = 1'b0;
                  out_valid_nxt        = 1'b1;
                  state_nxt            = ST_SIGN;
                end else if (val_mag == '0) begin
                  // zero is the single digit 0
                  dig_we    = 1'b1;
                  dig_waddr = '0;
                  dig_wdata = '0;
                  idx_nxt   = '0;
                  state_nxt = ST_RD;
                end else begin
                  state_nxt = ST_DIV;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SIGN: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == BIT_W'(VALUE_W - 1)) begin
          // remainder is the next digit, quotient carries on
          dig_we   = 1'b1;
          ndig_nxt = ndig_r + 1'b1;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          if (quo_step == '0) begin
            idx_nxt   = ndig_r[DIDX_W-1:0];
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        out_rsp_nxt.out_char = ram_rdata;
        out_rsp_nxt.last     = (idx_r == '0);
        out_valid_nxt        = 1'b1;
        state_nxt            = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // requests are only taken while the sequencer is idle
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_rsp_r;

endmodule

>>> design/sirtd_checker.sv
// ----------------------------------------------------------------------------
// sirtd_checker: port level checks for the radix digit unit
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sirtd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input sirtd_pkg::in_req_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input sirtd_pkg::out_rsp_t out_data
);
  import sirtd_pkg::*;

  // stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // no new request is taken while a character is pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request channel open while a character is pending");

  // the final character ends the conversion
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid && !in_stall)
    else $error("activity after final character");

  // a minus sign is never a final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_char == SYM_MINUS |-> !out_data.last)
    else $error("minus sign flagged as final character");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind signed_integer_to_radix_digits_unit sirtd_checker u_sirtd_checker (.*);

>>> tb/signed_integer_to_radix_digits_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_unit_tb: self-checking bench for the digit unit
// Builds digit alphabets through clear and append requests and converts signed
// values. A scoreboard predicts every emitted character and checks the result
// stream in order, under several sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------

import sirtd_pkg::*;

class digit_string_board;
  logic [SYM_W-1:0] alphabet [MAX_SYMBOLS];
  bit               seen [SYM_COUNT];
  int unsigned      alpha_len;
  bit               alpha_bad;
  out_rsp_t         char_queue [$];
  int               errors;

  function new();
    alpha_len = 0;
    alpha_bad = 1'b0;
    errors    = 0;
    foreach (seen[i]) seen[i] = 1'b0;
  endfunction

  function int pending();
    return char_queue.size();
  endfunction

  function void expect_char(logic [SYM_W-1:0] ch, logic fin);
    out_rsp_t c;
    c.out_char = ch;
    c.last     = fin;
    char_queue.push_back(c);
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // update the alphabet copy and queue the characters a request produces
  function void note_request(in_req_t req);
    logic [VALUE_W-1:0] mag;
    logic [SYM_W-1:0]   digits [MAX_DIGITS];
    int                 n;
    n = 0;
    case (req.opcode)
      OP_CLEAR: begin
        foreach (seen[i]) seen[i] = 1'b0;
        alpha_len = 0;
        alpha_bad = 1'b0;
      end
      OP_APPEND: begin
        if (req.symbol != '0) begin
          if (alpha_len >= MAX_SYMBOLS) begin
            alpha_bad = 1'b1;
          end else begin
            if (req.symbol == SYM_PLUS || req.symbol == SYM_MINUS || seen[req.symbol])
              alpha_bad = 1'b1;
            seen[req.symbol]    = 1'b1;
            alphabet[alpha_len] = req.symbol;
            alpha_len++;
          end
        end
      end
      OP_CONVERT: begin
        if (!alpha_bad && alpha_len > 1) begin
          mag = req.value;
          if (req.value[VALUE_W-1]) begin
            mag = -mag;
            expect_char(SYM_MINUS, 1'b0);
          end
          if (mag == '0) begin
            expect_char(alphabet[0], 1'b1);
          end else begin
            while (mag != '0 && n < MAX_DIGITS) begin
              digits[n] = SYM_W'(mag % alpha_len);
              mag       = mag / alpha_len;
              n++;
            end
            while (n > 0) begin
              n--;
              expect_char(alphabet[digits[n]], n == 0);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task check_char(out_rsp_t got);
    out_rsp_t want;
    if (char_queue.size() == 0) begin
      report_mismatch($sformatf("char %02h last %0b with nothing expected",
                                got.out_char, got.last));
    end else begin
      want = char_queue.pop_front();
      if (got.out_char !== want.out_char)
        report_mismatch($sformatf("char %02h, expected %02h", got.out_char, want.out_char));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b on char %02h, expected %0b",
                                  got.last, got.out_char, want.last));
    end
  endtask
endclass

module signed_integer_to_radix_digits_unit_tb;

  localparam int CLK_HALF     = 2;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int RANDOM_ITEMS = 60;

  // opcode the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [SYM_W-1:0] SYM_ZERO_CHAR = 8'h30;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;

  digit_string_board board = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit pressure_on    = 1'b0;
  int hold_count     = 0;
  int cycle_count    = 0;
  int item_count     = 0;

  signed_integer_to_radix_digits_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // receiver: random stall, plus one long hold-off counted here once pressure starts
  always @(posedge clk) begin
    if (pressure_on && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // result monitor: out_stall read here is the value the block saw at this edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_char(out_data);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("signed_integer_to_radix_digits_unit_tb: FAIL");
      $finish;
    end
  end

  // offer one request, with random idle cycles ahead of it, and wait for acceptance
  task automatic issue(input logic [1:0] opcode, input logic [SYM_W-1:0] symbol,
                       input logic signed [VALUE_W-1:0] value);
    in_req_t req;
    req.opcode = opcode;
    req.symbol = symbol;
    req.value  = value;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_request(req);
    // ignored requests do not count toward the stimulus length
    if (!(opcode == OP_UNUSED || (opcode == OP_APPEND && symbol == '0))) item_count++;
  endtask

  // unused fields carry random bits so every input bit toggles
  task automatic clear_alphabet();
    issue(OP_CLEAR, SYM_W'($urandom), VALUE_W'($urandom));
  endtask

  task automatic append(input logic [SYM_W-1:0] sym);
    issue(OP_APPEND, sym, VALUE_W'($urandom));
  endtask

  task automatic convert(input logic signed [VALUE_W-1:0] v);
    issue(OP_CONVERT, SYM_W'($urandom), v);
  endtask

  // clear, then append k distinct legal symbols in random order
  task automatic load_alphabet(input int k, output logic [SYM_W-1:0] last_sym);
    bit               used [SYM_COUNT];
    logic [SYM_W-1:0] sym;
    clear_alphabet();
    sym = SYM_ZERO_CHAR;
    for (int i = 0; i < k; i++) begin
      do sym = SYM_W'($urandom_range(1, 255));
      while (used[sym] || sym == SYM_PLUS || sym == SYM_MINUS);
      used[sym] = 1'b1;
      append(sym);
    end
    last_sym = sym;
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    logic signed [VALUE_W-1:0] v;
    v = VALUE_W'($urandom);
    case ($urandom_range(0, 7))
      0, 1: v = v >>> 22;          // small magnitude, either sign
      2:    v = VAL_MIN;
      3:    v = VAL_MAX;
      4:    v = v[0] ? '0 : '1;    // zero or minus one
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_sequence();
    int               k;
    int               kind;
    logic [SYM_W-1:0] last_sym;
    kind = $urandom_range(0, 9);
    k = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80) : $urandom_range(2, 16);
    if (kind <= 6) begin
      // well-formed alphabet, then a few conversions
      load_alphabet(k, last_sym);
      repeat ($urandom_range(1, 4)) convert(random_value());
    end else if (kind == 7) begin
      // alphabet spoiled by a sign symbol or a repeated symbol
      load_alphabet(k, last_sym);
      case ($urandom_range(0, 2))
        0:       append(SYM_PLUS);
        1:       append(SYM_MINUS);
        default: append(last_sym);
      endcase
      convert(random_value());
    end else if (kind == 8) begin
      // noise: any opcode, symbol zero now and then
      repeat ($urandom_range(3, 8))
        issue(2'($urandom_range(0, 3)),
              ($urandom_range(0, 3) == 0) ? '0 : SYM_W'($urandom_range(1, 255)),
              random_value());
    end else begin
      // alphabet too short for a radix
      clear_alphabet();
      if ($urandom_range(0, 1)) append(SYM_W'($urandom_range(1, 255)));
      convert(random_value());
    end
  endtask

  initial begin
    logic [SYM_W-1:0] last_sym;
    int               target;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty alphabet after reset emits nothing
    convert(VALUE_W'(7));
    // decimal alphabet
    clear_alphabet();
    for (int d = 0; d < 10; d++) append(SYM_W'(SYM_ZERO_CHAR + d));
    convert('0);
    convert(VAL_MAX);
    convert(VAL_MIN);
    convert('1);
    convert(VALUE_W'(10));
    // symbol zero and the unused opcode leave the state alone
    append('0);
    issue(OP_UNUSED, SYM_W'($urandom), VALUE_W'($urandom));
    convert(VALUE_W'(255));
    // sign symbol spoils the alphabet
    append(SYM_PLUS);
    convert(VALUE_W'(5));
    // single symbol gives no radix
    clear_alphabet();
    append(8'h61);
    convert(VALUE_W'(3));
    // binary: most negative value gives the longest string
    append(8'h62);
    convert(VAL_MIN);
    convert('1);
    // repeated symbol spoils the alphabet
    append(8'h61);
    convert(VALUE_W'(1));
    // minus sign spoils the alphabet
    clear_alphabet();
    append(8'h78);
    append(SYM_MINUS);
    convert(VALUE_W'(2));

    // pressure: receiver holds off while converts keep coming
    load_alphabet(10, last_sym);
    pressure_on <= 1'b1;
    repeat (6) convert(random_value());

    // random part in four idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 51; end
        default: begin send_idle_pct = 6; recv_stall_pct <= 6; end
      endcase
      target = item_count + RANDOM_ITEMS / 4;
      while (item_count < target) random_sequence();
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // catch any stray trailing characters
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("signed_integer_to_radix_digits_unit_tb: PASS");
    end else begin
      $display("signed_integer_to_radix_digits_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
